FILE: src/wavetable_voice_mixer_macros.svh
// Assertion macros shared by the checker of the voice mixer.
`ifndef WAVETABLE_VOICE_MIXER_MACROS_SVH
`define WAVETABLE_VOICE_MIXER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define WVM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define WVM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/wvm_pkg.sv
// Package of the voice mixer: constants, command and status types, oscillator functions.
`default_nettype none
package wvm_pkg;

   localparam int BLOCK_LEN = 64;
   localparam int VOICES    = 8;
   localparam int BUF_AW    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
   localparam int SLOT_W    = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Restoring divider for 2^24 / period: 25 dividend bits.
   localparam int DIV_STEPS = 25;
   localparam int DIV_CW    = 5;

   localparam logic [31:0] NOISE_SEED = 32'h0000_1234;
   localparam logic [31:0] NOISE_FILL = 32'h0000_ACE1;
   localparam logic [13:0] LEVEL_MAX  = 14'd4096;
   localparam logic [6:0]  PITCH_MAX  = 7'd119;

   typedef enum logic [1:0] {
      WAVE_SINE  = 2'd0,
      WAVE_TRI   = 2'd1,
      WAVE_SAW   = 2'd2,
      WAVE_NOISE = 2'd3
   } wave_type;

   typedef struct packed {
      logic              capture;
      logic              div_step;
      logic              mix_issue;
      logic              mix_done;
      logic              out_issue;
      logic              out_load;
      logic              first;
      logic              last_item;
      logic [BUF_AW-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic mix_en;
      logic last;
      logic pipe_busy;
      logic rsp_free;
   } status_type;

   function automatic logic [8:0] base_period(input logic [3:0] r);
      logic [8:0] v;
      unique case (r)
         4'd0:    v = 9'd428;
         4'd1:    v = 9'd404;
         4'd2:    v = 9'd381;
         4'd3:    v = 9'd360;
         4'd4:    v = 9'd339;
         4'd5:    v = 9'd320;
         4'd6:    v = 9'd302;
         4'd7:    v = 9'd285;
         4'd8:    v = 9'd269;
         4'd9:    v = 9'd254;
         4'd10:   v = 9'd240;
         4'd11:   v = 9'd226;
         default: v = 9'd226;
      endcase
      return v;
   endfunction

   // Note period from the clamped pitch: base table entry shifted by octave.
   function automatic logic [14:0] note_period(input logic signed [7:0] p);
      logic [6:0]  pc;
      logic [3:0]  oct;
      logic [6:0]  rem;
      logic [14:0] per;
      if (p < 0) begin
         pc = 7'd0;
      end else if (p[6:0] > PITCH_MAX) begin
         pc = PITCH_MAX;
      end else begin
         pc = p[6:0];
      end
      oct = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (pc >= 7'(12 * k)) oct = 4'(k);
      end
      rem = pc - 7'(oct) * 7'd12;
      per = {6'd0, base_period(rem[3:0])};
      if (oct < 4'd5) begin
         per = per << (4'd5 - oct);
      end else begin
         per = per >> (oct - 4'd5);
      end
      return per;
   endfunction

   function automatic logic signed [15:0] sine_rom(input logic [7:0] i);
      int ii;
      int x;
      int s;
      int para;
      ii   = int'(i);
      x    = ii - 128;
      s    = (ii < 128) ? (ii * 2 - 64) : (192 - ii * 2);
      para = 16384 - ((x * x) >>> 1);
      return 16'((para - 8192) * 3 + s * 8);
   endfunction

   function automatic logic [31:0] xorshift(input logic [31:0] v);
      logic [31:0] x;
      x = v;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   function automatic logic signed [15:0] wave_sample(input wave_type w,
                                                      input logic [7:0] i,
                                                      input logic [31:0] nx);
      logic signed [15:0] s;
      int ii;
      ii = int'(i);
      unique case (w)
         WAVE_SINE:  s = sine_rom(i);
         WAVE_TRI:   s = 16'(((ii < 128) ? (ii - 64) : (192 - ii)) * 256);
         WAVE_SAW:   s = 16'((ii - 128) * 256);
         WAVE_NOISE: s = 16'(int'(nx[13:0]) - 8192);
         default:    s = 16'sd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: src/wvm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module wvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

FILE: src/wvm_ctrl.sv
// Controller state machine of the voice mixer.
`default_nettype none
module wvm_ctrl import wvm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MIX,
      ST_DRAIN,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic [BUF_AW-1:0] idx_ff, idx_in;
   logic [DIV_CW-1:0] dcnt_ff, dcnt_in;

   localparam logic [BUF_AW-1:0] IDX_LAST = BUF_AW'(BLOCK_LEN - 1);
   localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_STEPS - 1);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      dcnt_in   = dcnt_ff;
      cmd       = '0;
      cmd.addr  = idx_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               dcnt_in     = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.mix_en) begin
               idx_in   = '0;
               state_in = status.last ? ST_OUT_RD : ST_IDLE;
            end else begin
               cmd.div_step = 1'b1;
               dcnt_in      = dcnt_ff + 1'b1;
               if (dcnt_ff == DIV_LAST) begin
                  idx_in   = '0;
                  state_in = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            cmd.mix_issue = 1'b1;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.mix_done = 1'b1;
               idx_in       = '0;
               state_in     = status.last ? ST_OUT_RD : ST_IDLE;
            end
         end
         ST_OUT_RD: begin
            if (status.rsp_free) begin
               cmd.out_issue = 1'b1;
               state_in      = ST_OUT_WAIT;
            end
         end
         ST_OUT_WAIT: begin
            cmd.out_load  = 1'b1;
            cmd.first     = (idx_ff == '0);
            cmd.last_item = (idx_ff == IDX_LAST);
            idx_in        = idx_ff + 1'b1;
            state_in      = (idx_ff == IDX_LAST) ? ST_IDLE : ST_OUT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/wvm_datapath.sv
// Datapath of the voice mixer: divider, oscillator, mix pipeline, buffer and output filter.
`default_nettype none
module wvm_datapath import wvm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        req_voice_index,
   input  wire logic              req_active,
   input  wire logic signed [7:0] req_pitch,
   input  wire logic              req_instr_valid,
   input  wire logic              req_has_envelope,
   input  wire logic [1:0]        req_wave,
   input  wire logic signed [15:0] req_envelope_point,
   input  wire logic              req_last_voice,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [15:0]     rsp_sample,
   output logic                   rsp_last_sample
);

   // Descriptor registers.
   wave_type           wave_ff;
   logic signed [13:0] lvl_ff;
   logic [14:0]        period_ff;
   logic               last_ff, mix_en_ff;
   logic [SLOT_W-1:0]  slot_ff;

   logic [31:0] phase_ff;
   logic [31:0] voice_phase_ff [VOICES];
   logic [31:0] noise_ff;

   logic [14:0] div_rem_ff;
   logic [24:0] div_dvd_ff, div_q_ff;

   logic signed [15:0] s_ff, buf_ff, prev_ff;
   logic signed [29:0] prod_ff;
   logic               v1_ff, v2_ff;
   logic [BUF_AW-1:0]  a1_ff, a2_ff;
   logic               block_open_ff, clean_ff;
   logic               rsp_valid_ff;

   // Capture logic.
   logic [SLOT_W-1:0]  req_slot;
   logic               req_in_range;
   logic signed [16:0] env_ext, env_abs;
   logic signed [13:0] req_lvl;

   assign req_slot     = SLOT_W'(req_voice_index);
   assign req_in_range = (32'(req_voice_index) < 32'(VOICES));
   assign env_ext      = 17'(req_envelope_point);
   assign env_abs      = (env_ext < 0) ? -env_ext : env_ext;
   assign req_lvl      = (!(req_instr_valid && req_has_envelope)) ? 14'sd0 :
                         (env_abs > 17'sd4096) ? LEVEL_MAX : env_abs[13:0];

   // Divider step.
   logic [14:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {div_rem_ff[13:0], div_dvd_ff[24]};
   assign rem_ge = (rem_sh >= period_ff);

   // Oscillator stage.
   logic [31:0]        step;
   logic [31:0]        noise_src, noise_nx;
   logic signed [15:0] osc_s;
   assign step      = {8'd0, div_q_ff[23:0]};
   assign noise_src = (noise_ff == '0) ? NOISE_FILL : noise_ff;
   assign noise_nx  = xorshift(noise_src);
   assign osc_s     = wave_sample(wave_ff, phase_ff[31:24], noise_nx);

   // Buffer and accumulate stage.
   logic [15:0]        rdata;
   logic signed [15:0] rd_s;
   logic signed [29:0] prod_c, prod_sh;
   logic signed [16:0] sum;
   logic signed [15:0] sat;

   assign rd_s    = clean_ff ? 16'sd0 : $signed(rdata);
   assign prod_c  = s_ff * lvl_ff;
   assign prod_sh = prod_ff >>> 13;
   assign sum     = 17'(buf_ff) + prod_sh[16:0];
   assign sat     = (sum > 17'sd32767) ? 16'sh7fff :
                    (sum < -17'sd32768) ? 16'sh8000 : sum[15:0];

   wvm_ram #(.WIDTH(16), .DEPTH(BLOCK_LEN)) u_buf (
      .clock (clock),
      .we    (v2_ff),
      .waddr (a2_ff),
      .wdata (sat),
      .raddr (cmd.addr),
      .rdata (rdata)
   );

   // Two-tap average, truncated toward zero.
   logic signed [15:0] prev_sel;
   logic signed [16:0] tot, tot_adj;
   assign prev_sel = cmd.first ? 16'sd0 : prev_ff;
   assign tot      = 17'(rd_s) + 17'(prev_sel);
   assign tot_adj  = tot + ((tot < 0) ? 17'sd1 : 17'sd0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wave_ff   <= req_instr_valid ? wave_type'(req_wave) : WAVE_SINE;
         lvl_ff    <= req_lvl;
         period_ff <= note_period(req_pitch);
         last_ff   <= req_last_voice;
         slot_ff   <= req_slot;
         if (req_in_range) phase_ff <= voice_phase_ff[req_slot];
         div_rem_ff <= '0;
         div_dvd_ff <= 25'h100_0000;
         div_q_ff   <= '0;
      end
      if (cmd.div_step) begin
         div_rem_ff <= rem_ge ? (rem_sh - period_ff) : rem_sh;
         div_dvd_ff <= div_dvd_ff << 1;
         div_q_ff   <= {div_q_ff[23:0], rem_ge};
      end
      if (cmd.mix_issue) begin
         s_ff     <= osc_s;
         phase_ff <= phase_ff + step;
      end
      a1_ff   <= cmd.addr;
      prod_ff <= prod_c;
      buf_ff  <= rd_s;
      a2_ff   <= a1_ff;
      if (cmd.out_load) begin
         rsp_sample      <= tot_adj[16:1];
         rsp_last_sample <= cmd.last_item;
         prev_ff         <= rd_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_en_ff     <= 1'b0;
         noise_ff      <= NOISE_SEED;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         block_open_ff <= 1'b0;
         clean_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int v = 0; v < VOICES; v++) voice_phase_ff[v] <= '0;
      end else begin
         v1_ff <= cmd.mix_issue;
         v2_ff <= v1_ff;
         if (cmd.capture) begin
            mix_en_ff <= req_active && req_in_range;
            if (!block_open_ff) begin
               block_open_ff <= 1'b1;
               clean_ff      <= 1'b1;
            end
         end
         if (cmd.mix_issue) begin
            voice_phase_ff[slot_ff] <= phase_ff + step;
            if (wave_ff == WAVE_NOISE) noise_ff <= noise_nx;
         end
         if (cmd.mix_done) clean_ff <= 1'b0;
         if (cmd.out_load && cmd.last_item) block_open_ff <= 1'b0;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.mix_en    = mix_en_ff;
   assign status.last      = last_ff;
   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

FILE: src/wavetable_voice_mixer.sv
// Top level of the wavetable voice mixer.
// A sounding voice passes through accept, the divider steps, the mix loop and a drain of the pipeline.
// A skipped voice returns from the divider state unmixed; the mix loop issues one sample per cycle.
// On the last voice, 64 samples follow from the registered buffer; an output stall holds each read.
// Reset is synchronous and active high; it clears phases, noise seed, framing and handshakes.
// The mix buffer needs no clearing pass: the first mix of each block reads it as zero.
`default_nettype none
module wavetable_voice_mixer import wvm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_voice_index,
   input  wire logic               req_active,
   input  wire logic signed [7:0]  req_pitch,
   input  wire logic               req_instr_valid,
   input  wire logic               req_has_envelope,
   input  wire logic [1:0]         req_wave,
   input  wire logic signed [15:0] req_envelope_point,
   input  wire logic               req_last_voice,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample,
   output logic                    rsp_last_sample
);

   // The controller sequences each sounding request through divide and mix phases and
   // emits the block after the last one; the datapath holds every register that carries data.
   cmd_type    cmd;
   status_type status;

   wvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The output register lets a new request be taken while the final sample waits.
   wvm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_voice_index    (req_voice_index),
      .req_active         (req_active),
      .req_pitch          (req_pitch),
      .req_instr_valid    (req_instr_valid),
      .req_has_envelope   (req_has_envelope),
      .req_wave           (req_wave),
      .req_envelope_point (req_envelope_point),
      .req_last_voice     (req_last_voice),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_last_sample    (rsp_last_sample)
   );

endmodule
`default_nettype wire

FILE: src/wvm_checker.sv
// Port-level checker of the voice mixer and its bind to the top level.
`default_nettype none
`include "wavetable_voice_mixer_macros.svh"
module wvm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_sample,
   input wire logic               rsp_last_sample
);

   `WVM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last_sample), "stalled response changed")
   `WVM_ASSERT(a_no_req_mid_block, rsp_valid && !rsp_last_sample |-> req_stall, "request taken while a block is being emitted")
   `WVM_ASSERT(a_busy_after_req, req_valid && !req_stall |=> req_stall, "request taken on the cycle after another")
   `WVM_ASSERT_ALWAYS(a_reset_quiet, !reset && $past(reset) |-> !rsp_valid, "response valid straight after reset")

endmodule

bind wavetable_voice_mixer wvm_checker u_chk (.*);
`default_nettype wire
